FILE: design/overlap_window_accumulate_macros.svh
// ----------------------------------------------------------------------------
// Overlap window accumulate assertion macros
// Shared concurrent assertion forms, clocked on clk_i and idle during reset.
// ----------------------------------------------------------------------------
`ifndef OVERLAP_WINDOW_ACCUMULATE_MACROS_SVH
`define OVERLAP_WINDOW_ACCUMULATE_MACROS_SVH

// Same-cycle or sequence property checked at every rising edge out of reset.
`define OWA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define OWA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/owa_pkg.sv
// ----------------------------------------------------------------------------
// Overlap window accumulate package
// Field widths, saturation limits and codes shared by the block and checker.
// ----------------------------------------------------------------------------
package owa_pkg;

  localparam int unsigned ColW    = 12;
  localparam int unsigned PixW    = 16;
  localparam int unsigned CoefW   = 12;
  localparam int unsigned AccW    = 28;
  localparam int unsigned AddW    = 22;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CoefW-1:0] CoefMax = CoefW'(2048);
  localparam logic [AccW-1:0]  AccMax  = {AccW{1'b1}};
  localparam logic [PixW-1:0]  PixReset = PixW'(255);

  // Operation carried by an input request.
  typedef enum logic {
    OP_ACCUM  = 1'b0,
    OP_FINISH = 1'b1
  } op_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAXIMUM = 2'd0,
    CFG_LIMIT   = 2'd1,
    CFG_ENABLE  = 2'd2
  } cfg_index_e;

  // One finished pixel waiting for the receiver.
  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic [ColW-1:0] column;
  } result_t;

endpackage

FILE: design/owa_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module owa_ram #(
  parameter int unsigned WIDTH = 28,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; a read of the address being written returns old data.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/overlap_window_accumulate.sv
// ----------------------------------------------------------------------------
// Overlap window accumulate
// Row accumulator for overlapped block windowing with rounding and clamping.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_stall_o) carries accumulate and finish
//   requests. An accumulate request adds (sample * coefficient) >> 6 to the
//   accumulator entry of its column and gives no result. A finish request
//   reads the entry, rounds, caps and optionally limits it, clears the entry
//   and sends one pixel on the output channel (out_valid_o / out_stall_i).
//   Registers are written through cfg_we_i / cfg_index_i / cfg_wdata_i; the
//   user must write only while the block is idle, which is not enforced.
//   Throughput is one request per cycle while in_stall_o is low. The
//   accumulator read-modify-write goes through one RAM read port with a
//   registered read, and a forwarding register covers back-to-back requests
//   to the same column. A finish result passes the first-stage register and
//   is then written into the output queue. After reset the block clears the
//   accumulator RAM one entry per cycle; in_stall_o stays high in that pass.
//   A two-entry output queue keeps results while the receiver stalls; outside
//   the clear pass the input stalls only when a new result could find it full.
// ----------------------------------------------------------------------------
module overlap_window_accumulate #(
  parameter int unsigned MAX_ROW_WIDTH = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input requests.
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         in_op_i,
  input  logic [owa_pkg::ColW-1:0]     in_column_i,
  input  logic [owa_pkg::PixW-1:0]     in_sample_value_i,
  input  logic [owa_pkg::CoefW-1:0]    in_coefficient_i,
  input  logic [owa_pkg::PixW-1:0]     in_centre_sample_i,
  // Output results.
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [owa_pkg::PixW-1:0]     out_pixel_out_o,
  output logic [owa_pkg::ColW-1:0]     out_column_out_o,
  // Configuration writes.
  input  logic                         cfg_we_i,
  input  logic [owa_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [owa_pkg::PixW-1:0]     cfg_wdata_i
);

  import owa_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ROW_WIDTH);
  localparam logic [AW-1:0] LastAddr = AW'(MAX_ROW_WIDTH - 1);

  // Request held for the read-modify-write cycle.
  typedef struct packed {
    logic            valid;
    logic            finish;
    logic            in_range;
    logic [ColW-1:0] column;
    logic [AddW-1:0] addend;
    logic [PixW-1:0] lo;
    logic [PixW-1:0] hi;
  } stage_t;

  // Configuration registers.
  logic [PixW-1:0] maximum_q;
  logic [PixW-1:0] limit_q;
  logic            enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maximum_q <= PixReset;
      limit_q   <= PixReset;
      enable_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_MAXIMUM: maximum_q <= cfg_wdata_i;
        CFG_LIMIT:   limit_q   <= cfg_wdata_i;
        CFG_ENABLE:  enable_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Clearing pass over the accumulator after reset.
  logic          clr_active_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      if (clr_addr_q == LastAddr) begin
        clr_active_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
    end
  end

  // Output queue bookkeeping and input flow control.
  logic          in_accept;
  logic          out_pop;
  logic          push;
  logic [1:0]    count_q;
  logic [1:0]    occupancy;
  stage_t        s1_q;

  assign push      = s1_q.valid && s1_q.finish;
  assign out_pop   = out_valid_o && !out_stall_i;
  assign occupancy = count_q + {1'b0, push};
  assign in_stall_o = clr_active_q || ((occupancy == 2'd2) && !out_pop);
  assign in_accept  = in_valid_i && !in_stall_o;

  // First stage: weight the sample and prepare the limit band.
  logic [CoefW-1:0]      coef_sat;
  logic [PixW+CoefW-1:0] product;
  logic [PixW:0]         hi_sum;
  stage_t                s1_d;

  always_comb begin
    coef_sat       = (in_coefficient_i > CoefMax) ? CoefMax : in_coefficient_i;
    product        = (PixW+CoefW)'(in_sample_value_i) * (PixW+CoefW)'(coef_sat);
    hi_sum         = {1'b0, in_centre_sample_i} + {1'b0, limit_q};
    s1_d.valid     = in_accept;
    s1_d.finish    = (op_e'(in_op_i) == OP_FINISH);
    s1_d.in_range  = (32'(in_column_i) < MAX_ROW_WIDTH);
    s1_d.column    = in_column_i;
    s1_d.addend    = product[PixW+CoefW-1:6];
    s1_d.lo        = (in_centre_sample_i > limit_q) ? (in_centre_sample_i - limit_q) : '0;
    s1_d.hi        = (hi_sum > {1'b0, maximum_q}) ? maximum_q : hi_sum[PixW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q <= s1_d;
    end
  end

  // Accumulator RAM.
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [AccW-1:0] ram_wdata;
  logic [AccW-1:0] ram_rdata;
  logic [AW-1:0]   s1_addr;
  logic            s1_write;
  logic [AccW-1:0] s1_wdata;

  assign s1_addr  = AW'(s1_q.column);
  assign s1_write = s1_q.valid && s1_q.in_range;

  always_comb begin
    if (clr_active_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_write;
      ram_waddr = s1_addr;
      ram_wdata = s1_wdata;
    end
  end

  owa_ram #(
    .WIDTH (AccW),
    .DEPTH (MAX_ROW_WIDTH)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (AW'(in_column_i)),
    .rdata_o (ram_rdata)
  );

  // Forwarding of the write made at the edge where the current read happened.
  logic            fwd_valid_q;
  logic [AW-1:0]   fwd_addr_q;
  logic [AccW-1:0] fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= s1_write && !clr_active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= s1_addr;
    fwd_data_q <= s1_wdata;
  end

  // Second stage: update the entry or finish the pixel.
  logic [AccW-1:0] cur;
  logic [AccW:0]   acc_sum;
  logic [AccW:0]   round_sum;
  logic [AccW-5:0] rounded;
  logic [PixW-1:0] capped;
  logic [PixW-1:0] raised;
  logic [PixW-1:0] pixel;

  always_comb begin
    if (!s1_q.in_range) begin
      cur = '0;
    end else if (fwd_valid_q && (fwd_addr_q == s1_addr)) begin
      cur = fwd_data_q;
    end else begin
      cur = ram_rdata;
    end
    acc_sum   = {1'b0, cur} + (AccW+1)'(s1_q.addend);
    s1_wdata  = s1_q.finish ? '0 : (acc_sum[AccW] ? AccMax : acc_sum[AccW-1:0]);
    round_sum = {1'b0, cur} + (AccW+1)'(16);
    rounded   = round_sum[AccW:5];
    capped    = (rounded > (AccW-4)'(maximum_q)) ? maximum_q : rounded[PixW-1:0];
    // Low bound first, then the high bound wins on an empty band.
    raised    = (capped < s1_q.lo) ? s1_q.lo : capped;
    pixel     = enable_q ? ((raised > s1_q.hi) ? s1_q.hi : raised) : capped;
  end

  // Two-entry output queue.
  result_t q_mem_q [2];
  logic    wr_ptr_q;
  logic    rd_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_q + {1'b0, push} - {1'b0, out_pop};
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (out_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= '{pixel: pixel, column: s1_q.column};
    end
  end

  assign out_valid_o      = (count_q != 2'd0);
  assign out_pixel_out_o  = q_mem_q[rd_ptr_q].pixel;
  assign out_column_out_o = q_mem_q[rd_ptr_q].column;

endmodule

FILE: design/owa_checker.sv
// ----------------------------------------------------------------------------
// Overlap window accumulate checker
// Port-level assertions on result timing, output holding and the reset pass.
// ----------------------------------------------------------------------------
`include "overlap_window_accumulate_macros.svh"

module owa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         in_op_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [owa_pkg::PixW-1:0]     out_pixel_out_o,
  input logic [owa_pkg::ColW-1:0]     out_column_out_o
);

  import owa_pkg::*;

  logic fin_accept;

  assign fin_accept = in_valid_i && !in_stall_o && (op_e'(in_op_i) == OP_FINISH);

  // An accepted finish request has a pixel waiting once the first-stage register and the output queue have taken it.
  `OWA_ASSERT(a_finish_latency, fin_accept |-> ##2 out_valid_o, "finish result missing")

  // The output valid only rises for a finish request that went through the first-stage register.
  `OWA_ASSERT(a_no_spurious, $rose(out_valid_o) |-> $past(fin_accept, 2), "result without finish")

  // The clearing pass holds off requests right after reset.
  `OWA_ASSERT(a_clear_stall, !$past(rst_ni) |-> in_stall_o, "request taken during clear")

  // A stalled result stays in place.
  `OWA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_pixel_out_o) && $stable(out_column_out_o),
    "stalled result changed")

endmodule

bind overlap_window_accumulate owa_checker u_owa_checker (.*);
